### sv/ip_ban_filter_table_top_assert.svh
// ----------------------------------------------------------------------------
// ip ban filter table assertion macros
// concurrent checks used at the end of the top level, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef IP_BAN_FILTER_TABLE_TOP_ASSERT_SVH
`define IP_BAN_FILTER_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define IBF_ASSERT_IMP(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("ip ban filter table: same-cycle check failed");
// next-cycle implication
`define IBF_ASSERT_NXT(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("ip ban filter table: next-cycle check failed");
`else
`define IBF_ASSERT_IMP(label, ck, rn, pre, post)
`define IBF_ASSERT_NXT(label, ck, rn, pre, post)
`endif

`endif

### sv/ibf_pkg.sv
// ----------------------------------------------------------------------------
// ibf_pkg
// types, codes and helpers shared by the ip ban filter table modules
// ----------------------------------------------------------------------------
package ibf_pkg;

    // operation codes
    localparam logic [1:0] FUNC_CHECK    = 2'd0;
    localparam logic [1:0] FUNC_ADD      = 2'd1;
    localparam logic [1:0] FUNC_REM_ADDR = 2'd2;
    localparam logic [1:0] FUNC_REM_SLOT = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_BAD_SLOT  = 2'd3;

    // filter modes, anything above ban list is an allow list
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_BAN = 2'd1;

    // compare word marking a free entry
    localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;

    localparam int SLOT_W  = 7;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [1:0]        func;
        logic [31:0]       address;
        logic [31:0]       duration_ticks;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       current_time;
    } in_item_t;

    typedef struct packed {
        logic               discard;
        logic [1:0]         status;
        logic               added_new;
        logic [COUNT_W-1:0] entry_count;
    } out_item_t;

    // one table entry, the mask follows from the compare word
    typedef struct packed {
        logic [31:0] compare;
        logic [31:0] end_time;
    } entry_t;

    // compare unit flags
    typedef struct packed {
        logic match;
        logic same;
        logic free;
        logic expired;
    } cmp_res_t;

    // 0xff in every nonzero octet
    function automatic logic [31:0] mask_of(input logic [31:0] a);
        logic [31:0] m;
        m = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (a[8*k +: 8] != 8'd0)
            begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

### sv/ip_ban_filter_table_top.sv
// Operation: a check with mode off or an empty table goes straight to the result, else it
// walks down, then runs a compaction pass when an expired entry was met; add and remove by
// address walk up, remove by slot compacts from the slot upward or reports a bad slot.
// Flow: one item at a time, the next accepted from the edge that offers the result,
// paced by the entry store read port and the single compare unit.
// Reset: entry count zero, filter mode ban list; entry store contents stay undefined.
// ----------------------------------------------------------------------------
// ip_ban_filter_table_top
// ordered ipv4 ban table with check, add and remove, one entry walked per cycle
// ----------------------------------------------------------------------------
`include "ip_ban_filter_table_top_assert.svh"

module ip_ban_filter_table_top
    import ibf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  in_item_t   req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output out_item_t  rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IDX_W:0] ADDR_LIM = (IDX_W + 1)'(MAX_ENTRIES);

    logic [1:0]       mode_reg;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    entry_t           ram_wr_data;
    logic [IDX_W-1:0] ram_rd_addr;
    entry_t           ram_rd_data;
    logic             wr_addr_ok;
    logic             added_ok;

    // filter mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BAN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    // entry store
    ibf_ram #(
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // sequencer with compare unit
    ibf_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mode        (mode_reg),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // checks
    assign wr_addr_ok = ({1'b0, ram_wr_addr} < ADDR_LIM);
    assign added_ok   = (rsp.status == STATUS_DONE) && !rsp.discard;

    `IBF_ASSERT_IMP(a_no_write_when_idle, clk, rst_n, ram_wr_en, !req_ready)
    `IBF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    `IBF_ASSERT_IMP(a_write_in_range, clk, rst_n, ram_wr_en, wr_addr_ok)
    `IBF_ASSERT_IMP(a_added_clean, clk, rst_n, rsp_valid && rsp.added_new, added_ok)

endmodule

### sv/ibf_cmp.sv
// ----------------------------------------------------------------------------
// ibf_cmp
// shared compare unit: match, identity, free marker and expiry of one entry
// ----------------------------------------------------------------------------
module ibf_cmp
    import ibf_pkg::*;
(
    input  entry_t      entry,
    input  logic [31:0] key,
    input  logic [31:0] now,
    output cmp_res_t    res
);

    // flags of the entry against the held address and time
    always_comb
    begin
        res.free    = (entry.compare == FREE_MARK);
        res.same    = (entry.compare == key);
        res.match   = ((key & mask_of(entry.compare)) == entry.compare);
        res.expired = !res.free && (entry.end_time != 32'd0) && (entry.end_time <= now);
    end

endmodule

### sv/ibf_ram.sv
// ----------------------------------------------------------------------------
// ibf_ram
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ibf_ram
    import ibf_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/ibf_seq.sv
// ----------------------------------------------------------------------------
// ibf_seq
// sequencer: walks the entry store one entry a cycle through the compare unit,
// adds, removes and compacts entries, holds the result register
// ----------------------------------------------------------------------------
module ibf_seq
    import ibf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  in_item_t         req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output out_item_t        rsp,
    input  logic [1:0]       mode,
    output logic             ram_wr_en,
    output logic [IDX_W-1:0] ram_wr_addr,
    output entry_t           ram_wr_data,
    output logic [IDX_W-1:0] ram_rd_addr,
    input  entry_t           ram_rd_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_DN,
        S_SCAN_UP,
        S_COMPACT,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       func_reg, func_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      now_reg, now_next;
    logic [31:0]      end_reg, end_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic             pv_reg, pv_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic             any_exp_reg, any_exp_next;
    logic             drop_exp_reg, drop_exp_next;
    logic             discard_reg, discard_next;
    logic [1:0]       status_reg, status_next;
    logic             added_reg, added_next;
    logic             rsp_valid_reg, rsp_valid_next;
    out_item_t        rsp_reg, rsp_next;

    cmp_res_t         cres;
    logic             ban_list;
    logic [32:0]      end_sum;
    logic [CW-1:0]    cnt_ext;
    logic [CW-1:0]    slot_ext;
    logic [CNT_W-1:0] ptr_m1;

    // shared compare unit on the entry just read
    ibf_cmp u_cmp (
        .entry (ram_rd_data),
        .key   (addr_reg),
        .now   (now_reg),
        .res   (cres)
    );

    assign ban_list  = (mode == MODE_BAN);
    assign end_sum   = {1'b0, req.current_time} + {1'b0, req.duration_ticks};
    assign cnt_ext   = CW'(cnt_reg);
    assign slot_ext  = CW'(req.slot);
    assign ptr_m1    = ptr_reg - CNT_W'(1);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state and datapath control
    always_comb
    begin
        logic exp_seen;
        logic stop;
        logic hit;

        state_next     = state_reg;
        func_next      = func_reg;
        addr_next      = addr_reg;
        now_next       = now_reg;
        end_next       = end_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        w_next         = w_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        any_exp_next   = any_exp_reg;
        drop_exp_next  = drop_exp_reg;
        discard_next   = discard_reg;
        status_next    = status_reg;
        added_next     = added_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = w_reg[IDX_W-1:0];
        ram_wr_data    = ram_rd_data;
        ram_rd_addr    = ptr_reg[IDX_W-1:0];
        exp_seen       = 1'b0;
        stop           = 1'b0;
        hit            = 1'b0;

        // result taken downstream
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next     = req.func;
                    addr_next     = req.address;
                    now_next      = req.current_time;
                    if (req.duration_ticks == 32'd0)
                    begin
                        end_next = 32'd0;
                    end
                    else if (end_sum[32])
                    begin
                        end_next = 32'hFFFF_FFFF;
                    end
                    else
                    begin
                        end_next = end_sum[31:0];
                    end
                    discard_next  = 1'b0;
                    status_next   = STATUS_DONE;
                    added_next    = 1'b0;
                    pv_next       = 1'b0;
                    any_exp_next  = 1'b0;
                    drop_exp_next = 1'b0;
                    ptr_next      = '0;
                    unique case (req.func)
                        FUNC_CHECK:
                        begin
                            if (mode == MODE_OFF)
                            begin
                                state_next = S_DONE;
                            end
                            else if (cnt_reg == '0)
                            begin
                                discard_next = !ban_list;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = cnt_reg;
                                state_next = S_SCAN_DN;
                            end
                        end
                        FUNC_ADD, FUNC_REM_ADDR:
                        begin
                            state_next = S_SCAN_UP;
                        end
                        default:
                        begin
                            // remove by slot, one-based
                            if (slot_ext == '0 || slot_ext > cnt_ext)
                            begin
                                status_next = STATUS_BAD_SLOT;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                w_next     = CNT_W'(slot_ext - CW'(1));
                                ptr_next   = CNT_W'(slot_ext);
                                state_next = S_COMPACT;
                            end
                        end
                    endcase
                end
            end

            S_SCAN_DN:
            begin
                // issue the next lower entry
                if (ptr_reg != '0)
                begin
                    ram_rd_addr = ptr_m1[IDX_W-1:0];
                    ptr_next    = ptr_m1;
                    pv_next     = 1'b1;
                    pidx_next   = ptr_m1[IDX_W-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end
                // judge the entry read last cycle
                if (pv_reg)
                begin
                    exp_seen = any_exp_reg | cres.expired;
                    if (!cres.expired && cres.match)
                    begin
                        stop         = 1'b1;
                        discard_next = ban_list;
                    end
                    else if (pidx_reg == '0)
                    begin
                        stop         = 1'b1;
                        discard_next = !ban_list;
                    end
                    if (stop)
                    begin
                        pv_next = 1'b0;
                        if (exp_seen)
                        begin
                            // squeeze out expired entries from the stopping point up
                            w_next        = CNT_W'(pidx_reg);
                            ptr_next      = CNT_W'(pidx_reg);
                            drop_exp_next = 1'b1;
                            state_next    = S_COMPACT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        any_exp_next = exp_seen;
                    end
                end
            end

            S_SCAN_UP:
            begin
                // issue the next higher entry
                if (ptr_reg < cnt_reg)
                begin
                    ram_rd_addr = ptr_reg[IDX_W-1:0];
                    ptr_next    = ptr_reg + CNT_W'(1);
                    pv_next     = 1'b1;
                    pidx_next   = ptr_reg[IDX_W-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg)
                begin
                    if (func_reg == FUNC_ADD)
                    begin
                        hit = cres.free | cres.same;
                    end
                    else
                    begin
                        hit = cres.same;
                    end
                end
                if (hit)
                begin
                    pv_next = 1'b0;
                    if (func_reg == FUNC_ADD)
                    begin
                        // reuse a free or identical entry
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = pidx_reg;
                        ram_wr_data = '{compare: addr_reg, end_time: end_reg};
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // close the gap above the removed entry
                        w_next     = CNT_W'(pidx_reg);
                        ptr_next   = CNT_W'(pidx_reg) + CNT_W'(1);
                        state_next = S_COMPACT;
                    end
                end
                else if (ptr_reg == cnt_reg)
                begin
                    pv_next    = 1'b0;
                    state_next = S_DONE;
                    if (func_reg == FUNC_ADD)
                    begin
                        if (cnt_reg >= CNT_MAX)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = cnt_reg[IDX_W-1:0];
                            ram_wr_data = '{compare: addr_reg, end_time: end_reg};
                            cnt_next    = cnt_reg + CNT_W'(1);
                            added_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
            end

            S_COMPACT:
            begin
                // read upward, write back every kept entry at the write pointer
                if (ptr_reg < cnt_reg)
                begin
                    ram_rd_addr = ptr_reg[IDX_W-1:0];
                    ptr_next    = ptr_reg + CNT_W'(1);
                    pv_next     = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg)
                begin
                    if (!(drop_exp_reg && cres.expired))
                    begin
                        ram_wr_en = 1'b1;
                        w_next    = w_reg + CNT_W'(1);
                    end
                end
                else if (ptr_reg == cnt_reg)
                begin
                    cnt_next   = w_reg;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hand over once the result register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.discard     = discard_reg;
                    rsp_next.status      = status_reg;
                    rsp_next.added_new   = added_reg;
                    rsp_next.entry_count = cnt_ext[COUNT_W-1:0];
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FUNC_CHECK;
            addr_reg      <= '0;
            now_reg       <= '0;
            end_reg       <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            w_reg         <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            any_exp_reg   <= 1'b0;
            drop_exp_reg  <= 1'b0;
            discard_reg   <= 1'b0;
            status_reg    <= STATUS_DONE;
            added_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            addr_reg      <= addr_next;
            now_reg       <= now_next;
            end_reg       <= end_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            w_reg         <= w_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            any_exp_reg   <= any_exp_next;
            drop_exp_reg  <= drop_exp_next;
            discard_reg   <= discard_next;
            status_reg    <= status_next;
            added_reg     <= added_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

### tb/ip_ban_filter_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_ban_filter_table_top_tb
// self-checking bench for the ip ban filter table: a ledger class keeps its own
// copy of the table and filter mode, predicts the result of every accepted
// request and compares it with what comes back; random gaps on both sides
// ----------------------------------------------------------------------------
module ip_ban_filter_table_top_tb;
    import ibf_pkg::*;

    localparam int         TABLE_DEPTH   = 64;
    localparam int         POOL_SIZE     = 16;
    localparam int         PHASES        = 5;
    localparam int         PHASE_ITEMS   = 250;
    // longest check walk with compaction plus margin
    localparam int         SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam logic [1:0] MODE_ALLOW    = 2'd2;
    localparam logic [1:0] MODE_ALLOW_HI = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    in_item_t   req;
    logic       rsp_valid;
    logic       rsp_ready;
    out_item_t  rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    bit         tx_burst;
    bit         rx_burst;
    bit [31:0]  tick_now;
    bit [31:0]  addr_pool [POOL_SIZE];
    int         cycles;

    // own copy of the ban table, expected verdicts in order of acceptance
    class ban_verdict_ledger;
        bit [31:0] entry_word  [TABLE_DEPTH];
        bit [31:0] entry_keep  [TABLE_DEPTH];
        bit [31:0] entry_until [TABLE_DEPTH];
        int        held;
        bit [1:0]  mode;
        out_item_t awaited [$];
        int        mismatches;

        function new();
            held       = 0;
            mode       = MODE_BAN;
            mismatches = 0;
        endfunction

        function bit [31:0] octet_mask(bit [31:0] a);
            return {(a[31:24] != 8'd0) ? 8'hFF : 8'h00,
                    (a[23:16] != 8'd0) ? 8'hFF : 8'h00,
                    (a[15:8]  != 8'd0) ? 8'hFF : 8'h00,
                    (a[7:0]   != 8'd0) ? 8'hFF : 8'h00};
        endfunction

        // remove one entry and shift the rest down
        function void close_gap(int idx);
            for (int k = idx; k + 1 < held; k++)
            begin
                entry_word[k]  = entry_word[k + 1];
                entry_keep[k]  = entry_keep[k + 1];
                entry_until[k] = entry_until[k + 1];
            end
            held--;
        endfunction

        // top-down walk, expired entries compacted on the way
        function bit walk_check(bit [31:0] a, bit [31:0] now);
            bit ban_list;
            if (mode == MODE_OFF)
                return 1'b0;
            ban_list = (mode == MODE_BAN);
            for (int j = held - 1; j >= 0; j--)
            begin
                if (entry_word[j] != FREE_MARK && entry_until[j] != 32'd0 &&
                    entry_until[j] <= now)
                    close_gap(j);
                else if ((a & entry_keep[j]) == entry_word[j])
                    return ban_list;
            end
            return !ban_list;
        endfunction

        function void set_mode(bit [1:0] m);
            mode = m;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(in_item_t it);
            out_item_t v;
            bit [31:0] m;
            bit [32:0] sum;
            int        idx;
            v   = '0;
            m   = octet_mask(it.address);
            idx = -1;
            case (it.func)
                FUNC_CHECK:
                    v.discard = walk_check(it.address, it.current_time);
                FUNC_ADD:
                begin
                    // lowest free or identical entry, else append
                    for (int i = 0; i < held; i++)
                    begin
                        if (idx < 0 && (entry_word[i] == FREE_MARK ||
                            (entry_word[i] == it.address && entry_keep[i] == m)))
                            idx = i;
                    end
                    if (idx < 0)
                    begin
                        if (held >= TABLE_DEPTH)
                            v.status = STATUS_FULL;
                        else
                        begin
                            idx = held;
                            held++;
                            v.added_new = 1'b1;
                        end
                    end
                    if (idx >= 0)
                    begin
                        sum = {1'b0, it.current_time} + {1'b0, it.duration_ticks};
                        entry_word[idx] = it.address;
                        entry_keep[idx] = m;
                        if (it.duration_ticks == 32'd0)
                            entry_until[idx] = 32'd0;
                        else
                            entry_until[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                end
                FUNC_REM_ADDR:
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        if (idx < 0 && entry_word[i] == it.address && entry_keep[i] == m)
                            idx = i;
                    end
                    if (idx >= 0)
                        close_gap(idx);
                    else
                        v.status = STATUS_NOT_FOUND;
                end
                FUNC_REM_SLOT:
                begin
                    if (it.slot != 0 && int'(it.slot) <= held)
                        close_gap(int'(it.slot) - 1);
                    else
                        v.status = STATUS_BAD_SLOT;
                end
            endcase
            v.entry_count = COUNT_W'(held);
            awaited.push_back(v);
        endfunction

        function void check_verdict(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: discard %0d st %0d new %0d count %0d",
                             got.discard, got.status, got.added_new, got.entry_count);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.discard !== want.discard || got.status !== want.status ||
                got.added_new !== want.added_new || got.entry_count !== want.entry_count)
            begin
                if (mismatches < 10)
                    $display("mismatch at %0t: expected discard %0d st %0d new %0d count %0d,%s",
                             $realtime, want.discard, want.status, want.added_new,
                             want.entry_count, " got");
                if (mismatches < 10)
                    $display("    got discard %0d st %0d new %0d count %0d",
                             got.discard, got.status, got.added_new, got.entry_count);
                mismatches++;
            end
        endfunction
    endclass

    ban_verdict_ledger ledger;

    ip_ban_filter_table_top #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic in_item_t make_req(logic [1:0] f, logic [31:0] a, logic [31:0] d,
                                          logic [SLOT_W-1:0] s, logic [31:0] t);
        in_item_t it;
        it.func           = f;
        it.address        = a;
        it.duration_ticks = d;
        it.slot           = s;
        it.current_time   = t;
        return it;
    endfunction

    // address with some octets zeroed, so masks vary
    function automatic bit [31:0] fresh_address();
        bit [31:0] a;
        for (int k = 0; k < 4; k++)
            a[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        return a;
    endfunction

    function automatic in_item_t random_request(int add_pct, int fresh_pct);
        in_item_t    it;
        int unsigned r;
        bit [31:0]   pooled;
        it     = '0;
        pooled = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 99) < add_pct)
            it.func = FUNC_ADD;
        else
        begin
            case ($urandom_range(0, 3))
                0, 1:    it.func = FUNC_CHECK;
                2:       it.func = FUNC_REM_ADDR;
                default: it.func = FUNC_REM_SLOT;
            endcase
        end

        // address, mostly from the pool so adds, checks and removes meet
        r = $urandom_range(0, 199);
        case (it.func)
            FUNC_ADD:
            begin
                if (r < 2)
                    it.address = FREE_MARK;
                else if (r == 2)
                    it.address = 32'd0;
                else if (r < 2 * fresh_pct)
                    it.address = fresh_address();
                else
                    it.address = pooled;
            end
            FUNC_CHECK:
            begin
                if (r < 60)
                    it.address = $urandom;
                else if (r < 100)
                    it.address = pooled;
                else
                begin
                    // fill masked-out octets so only the mask lets it match
                    it.address = pooled;
                    for (int k = 0; k < 4; k++)
                        if (it.address[8*k +: 8] == 8'd0)
                            it.address[8*k +: 8] = 8'($urandom_range(0, 255));
                end
            end
            FUNC_REM_ADDR:
                it.address = (r < 150) ? pooled : fresh_address();
            default:
                it.address = $urandom;
        endcase

        // duration: permanent, short, random or near saturation
        r = $urandom_range(0, 99);
        if (r < 30)
            it.duration_ticks = 32'd0;
        else if (r < 85)
            it.duration_ticks = $urandom_range(1, 60);
        else if (r < 95)
            it.duration_ticks = $urandom;
        else
            it.duration_ticks = 32'hFFFF_FFFF - $urandom_range(0, 3);

        // slot, mostly in range
        r = $urandom_range(0, 99);
        if (r < 70)
            it.slot = (ledger.held > 0) ? SLOT_W'($urandom_range(1, ledger.held)) : 7'd1;
        else if (r < 78)
            it.slot = 7'd0;
        else if (r < 85)
            it.slot = SLOT_W'(ledger.held + 1);
        else
            it.slot = SLOT_W'($urandom_range(0, 127));

        // time mostly creeps forward, sometimes jumps
        r = $urandom_range(0, 199);
        if (r == 0)
            tick_now = $urandom;
        else if (r == 1)
            tick_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
        else
            tick_now = tick_now + $urandom_range(0, 6);
        it.current_time = tick_now;
        return it;
    endfunction

    // one request item with a random lead-in gap
    task automatic send_request(in_item_t it);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        ledger.note_request(it);
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
    endtask

    // hold off until every expected result is back
    task automatic drain();
        req_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    // result side with random stalls
    initial
    begin
        int stall;
        rsp_ready <= 1'b0;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
            ledger.check_verdict(rsp);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
        end
    end

    // stimulus
    initial
    begin
        bit [1:0] phase_mode [PHASES];
        int       add_weight [PHASES];
        int       fresh_weight [PHASES];
        phase_mode   = '{MODE_BAN, MODE_ALLOW, MODE_OFF, MODE_ALLOW_HI, MODE_BAN};
        add_weight   = '{35, 35, 70, 25, 45};
        fresh_weight = '{30, 30, 75, 30, 40};
        ledger    = new();
        tx_burst  = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= MODE_OFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset mode is ban list
        // empty table: check, missing address, slot zero and slot past the end
        send_request(make_req(FUNC_CHECK,    32'h0A00_0001, 32'd0, 7'd0, 32'd100));
        send_request(make_req(FUNC_REM_ADDR, 32'h0102_0304, 32'd0, 7'd0, 32'd100));
        send_request(make_req(FUNC_REM_SLOT, 32'h0000_0000, 32'd0, 7'd0, 32'd100));
        send_request(make_req(FUNC_REM_SLOT, 32'h0000_0000, 32'd0, 7'd1, 32'd100));
        // subnet entry, masked match, then same entry updated
        send_request(make_req(FUNC_ADD,      32'hC0A8_0000, 32'd0, 7'd0, 32'd100));
        send_request(make_req(FUNC_CHECK,    32'hC0A8_0709, 32'd0, 7'd0, 32'd101));
        send_request(make_req(FUNC_ADD,      32'hC0A8_0000, 32'd50, 7'd0, 32'd101));
        // timed entry, live one tick before its end, expired at its end
        send_request(make_req(FUNC_ADD,      32'h0A01_0203, 32'd5, 7'd0, 32'd100));
        send_request(make_req(FUNC_CHECK,    32'h0A01_0203, 32'd0, 7'd0, 32'd104));
        send_request(make_req(FUNC_CHECK,    32'h0A01_0203, 32'd0, 7'd0, 32'd105));
        // free marker never expires, walk stops above an expired entry
        send_request(make_req(FUNC_ADD,      FREE_MARK,     32'd7, 7'd0, 32'd110));
        send_request(make_req(FUNC_CHECK,    FREE_MARK,     32'd0, 7'd0, 32'd200));
        // free entry reused, end time saturates
        send_request(make_req(FUNC_ADD,      32'h0808_0808, 32'hFFFF_FFFF, 7'd0, 32'd200));
        // all-zero address matches everything
        send_request(make_req(FUNC_ADD,      32'h0000_0000, 32'd0, 7'd0, 32'd200));
        send_request(make_req(FUNC_CHECK,    32'h0101_0101, 32'd0, 7'd0, 32'd201));
        send_request(make_req(FUNC_REM_ADDR, 32'h0000_0000, 32'd0, 7'd0, 32'd201));
        send_request(make_req(FUNC_REM_ADDR, 32'h0000_0000, 32'd0, 7'd0, 32'd201));
        send_request(make_req(FUNC_REM_SLOT, 32'h0000_0000, 32'd0, 7'd64, 32'd201));
        send_request(make_req(FUNC_REM_SLOT, 32'h0000_0000, 32'd0, 7'd127, 32'd201));
        // near wrap: saturated end, then every entry expires at the top tick
        send_request(make_req(FUNC_ADD,      32'h0400_0004, 32'd32, 7'd0, 32'hFFFF_FFF0));
        send_request(make_req(FUNC_CHECK,    32'h0409_0904, 32'd0, 7'd0, 32'hFFFF_FFFF));
        send_request(make_req(FUNC_ADD,      32'h0102_0304, 32'd0, 7'd0, 32'd5));
        send_request(make_req(FUNC_REM_SLOT, 32'h0000_0000, 32'd0, 7'd1, 32'd5));

        // random phases, one filter mode each
        tick_now = 32'd1000;
        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
                addr_pool[i] = fresh_address();

            // mode change only once the block is idle
            drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_data  <= phase_mode[p];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            ledger.set_mode(phase_mode[p]);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_request(random_request(add_weight[p], fresh_weight[p]));
                if (p == 1 && n == PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
